>>> hdl/four_level_page_table_walker_macros.svh
// Assertion helpers used by the page table walker controller
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PGW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PGW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pgw_pkg.sv
`default_nettype none

package pgw_pkg;

    // Geometry of the tables and widths of the fields
    localparam int TABLE_PAGES_DEF = 16;
    localparam int IDX_W           = 9;
    localparam int FRAME_W         = 40;
    localparam int VA_W            = 48;
    localparam int PA_W            = 52;
    localparam int FLAG_W          = 12;
    localparam int ENTRY_W         = 64;
    localparam int CMD_W           = 2;
    localparam int ST_W            = 2;
    localparam int LVL_W           = 2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_MAP   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNMAP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_XLATE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [ST_W-1:0] ST_EXHAUSTED  = 2'd2;

    // Entry flag bits
    localparam logic [FLAG_W-1:0] FL_PRESENT  = 12'h001;
    localparam logic [FLAG_W-1:0] FL_TABLE    = 12'h003;
    localparam logic [LVL_W-1:0]  LEVEL_LEAF  = 2'd3;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [FRAME_W-1:0] a;
        logic [FRAME_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [FRAME_W-1:0] sum;
        logic               in_pool;
    } t_alu_rsp;

    // Table index of one walk level
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [LVL_W-1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> hdl/four_level_page_table_walker.sv
// An accepted start walks the levels with one registered table read (S_RD) and one
// check (S_CHK) per level, until the leaf or a missing entry, then strobes o_done; the
// next start is taken in the strobe cycle. Each table page created by map is first
// cleared through the single table port (S_ZERO), then linked into its parent (S_LINK).
// Reset: synchronous, active low; the root page is then cleared with busy high.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none

module four_level_page_table_walker #(
    parameter int TABLE_PAGES = pgw_pkg::TABLE_PAGES_DEF,
    localparam int PAGE_W = $clog2(TABLE_PAGES),
    localparam int ADDR_W = PAGE_W + pgw_pkg::IDX_W,
    localparam int PU_W   = $clog2(TABLE_PAGES + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pgw_pkg::FRAME_W-1:0]   i_cfg_wdata,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [pgw_pkg::CMD_W-1:0]     i_command,
    input  wire logic [pgw_pkg::VA_W-1:0]      i_virtual_address,
    input  wire logic [pgw_pkg::PA_W-1:0]      i_physical_address,
    input  wire logic [pgw_pkg::FLAG_W-1:0]    i_entry_flags,
    output logic                               o_done,
    output logic      [pgw_pkg::ST_W-1:0]      o_status,
    output logic      [pgw_pkg::PA_W-1:0]      o_physical_result,
    output logic                               o_invalidate_request
);

    logic [pgw_pkg::FRAME_W-1:0]  r_base;
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_addr;
    logic [pgw_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [pgw_pkg::ENTRY_W-1:0]  ram_rdata;
    pgw_pkg::t_alu_req            alu_req;
    pgw_pkg::t_alu_rsp            alu_rsp;
    logic [PU_W-1:0]              pages_used;

    // Pool base frame register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    pgw_ctrl #(.TABLE_PAGES(TABLE_PAGES)) u_ctrl (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (start),
        .o_busy               (busy),
        .i_command            (i_command),
        .i_virtual_address    (i_virtual_address),
        .i_physical_address   (i_physical_address),
        .i_entry_flags        (i_entry_flags),
        .i_base               (r_base),
        .o_done               (o_done),
        .o_status             (o_status),
        .o_physical_result    (o_physical_result),
        .o_invalidate_request (o_invalidate_request),
        .o_ram_we             (ram_we),
        .o_ram_addr           (ram_addr),
        .o_ram_wdata          (ram_wdata),
        .i_ram_rdata          (ram_rdata),
        .o_alu_req            (alu_req),
        .o_pages_used         (pages_used),
        .i_alu_rsp            (alu_rsp)
    );

    pgw_alu #(.TABLE_PAGES(TABLE_PAGES)) u_alu (
        .i_req   (alu_req),
        .i_limit (pages_used),
        .o_rsp   (alu_rsp)
    );

    pgw_ram #(.TABLE_PAGES(TABLE_PAGES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

>>> hdl/pgw_ram.sv
`default_nettype none

module pgw_ram #(
    parameter int TABLE_PAGES = pgw_pkg::TABLE_PAGES_DEF,
    localparam int PAGE_W = $clog2(TABLE_PAGES),
    localparam int ADDR_W = PAGE_W + pgw_pkg::IDX_W,
    localparam int DEPTH  = TABLE_PAGES * (1 << pgw_pkg::IDX_W)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [ADDR_W-1:0]            i_addr,
    input  wire logic [pgw_pkg::ENTRY_W-1:0]  i_wdata,
    output logic      [pgw_pkg::ENTRY_W-1:0]  o_rdata
);

    logic [pgw_pkg::ENTRY_W-1:0] r_mem [DEPTH];

    // Single port: registered read, with a write when enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

>>> hdl/pgw_alu.sv
`default_nettype none

module pgw_alu #(
    parameter int TABLE_PAGES = pgw_pkg::TABLE_PAGES_DEF,
    localparam int PU_W = $clog2(TABLE_PAGES + 1)
) (
    input  wire pgw_pkg::t_alu_req  i_req,
    input  wire logic [PU_W-1:0]    i_limit,
    output pgw_pkg::t_alu_rsp       o_rsp
);

    logic [pgw_pkg::FRAME_W-1:0] limit_ext;

    // Frame add or subtract, then bound check against the pages in use
    always_comb begin
        limit_ext = {{(pgw_pkg::FRAME_W - PU_W){1'b0}}, i_limit};
        if (i_req.op == pgw_pkg::ALU_ADD) begin
            o_rsp.sum = i_req.a + i_req.b;
        end else begin
            o_rsp.sum = i_req.a - i_req.b;
        end
        o_rsp.in_pool = (o_rsp.sum < limit_ext);
    end

endmodule

`default_nettype wire

>>> hdl/pgw_ctrl.sv
`default_nettype none
`include "four_level_page_table_walker_macros.svh"

module pgw_ctrl #(
    parameter int TABLE_PAGES = pgw_pkg::TABLE_PAGES_DEF,
    localparam int PAGE_W = $clog2(TABLE_PAGES),
    localparam int ADDR_W = PAGE_W + pgw_pkg::IDX_W,
    localparam int PU_W   = $clog2(TABLE_PAGES + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic [pgw_pkg::CMD_W-1:0]     i_command,
    input  wire logic [pgw_pkg::VA_W-1:0]      i_virtual_address,
    input  wire logic [pgw_pkg::PA_W-1:0]      i_physical_address,
    input  wire logic [pgw_pkg::FLAG_W-1:0]    i_entry_flags,
    input  wire logic [pgw_pkg::FRAME_W-1:0]   i_base,
    output logic                               o_done,
    output logic      [pgw_pkg::ST_W-1:0]      o_status,
    output logic      [pgw_pkg::PA_W-1:0]      o_physical_result,
    output logic                               o_invalidate_request,
    output logic                               o_ram_we,
    output logic      [ADDR_W-1:0]             o_ram_addr,
    output logic      [pgw_pkg::ENTRY_W-1:0]   o_ram_wdata,
    input  wire logic [pgw_pkg::ENTRY_W-1:0]   i_ram_rdata,
    output pgw_pkg::t_alu_req                  o_alu_req,
    output logic      [PU_W-1:0]               o_pages_used,
    input  wire pgw_pkg::t_alu_rsp             i_alu_rsp
);

    typedef enum logic [5:0] {
        S_BOOT = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD   = 6'b000100,
        S_CHK  = 6'b001000,
        S_ZERO = 6'b010000,
        S_LINK = 6'b100000
    } t_state;

    // Control state
    t_state                       r_state, n_state;
    logic [pgw_pkg::IDX_W-1:0]    r_cnt, n_cnt;
    logic [pgw_pkg::LVL_W-1:0]    r_level, n_level;
    logic [PU_W-1:0]              r_pages_used, n_pages_used;
    logic                         r_done, n_done;

    // Payload
    logic [PAGE_W-1:0]            r_page, n_page;
    logic [PAGE_W-1:0]            r_new_page, n_new_page;
    logic [pgw_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [pgw_pkg::VA_W-1:0]     r_va, n_va;
    logic [pgw_pkg::PA_W-1:0]     r_pa, n_pa;
    logic [pgw_pkg::FLAG_W-1:0]   r_flags, n_flags;
    logic [pgw_pkg::ST_W-1:0]     r_status, n_status;
    logic [pgw_pkg::PA_W-1:0]     r_phys, n_phys;
    logic                         r_inval, n_inval;

    logic [pgw_pkg::IDX_W-1:0]    idx;
    logic                         present;
    logic [pgw_pkg::FRAME_W-1:0]  entry_frame;

    assign idx         = pgw_pkg::level_index(r_va, r_level);
    assign present     = i_ram_rdata[0];
    assign entry_frame = i_ram_rdata[51:12];

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_level      = r_level;
        n_pages_used = r_pages_used;
        n_done       = 1'b0;
        n_page       = r_page;
        n_new_page   = r_new_page;
        n_cmd        = r_cmd;
        n_va         = r_va;
        n_pa         = r_pa;
        n_flags      = r_flags;
        n_status     = r_status;
        n_phys       = r_phys;
        n_inval      = r_inval;

        o_ram_we     = 1'b0;
        o_ram_addr   = {r_page, idx};
        o_ram_wdata  = '0;
        o_alu_req.op = pgw_pkg::ALU_SUB;
        o_alu_req.a  = entry_frame;
        o_alu_req.b  = i_base;

        case (r_state)
            S_BOOT: begin
                // clear the root page after reset
                o_ram_we   = 1'b1;
                o_ram_addr = {{PAGE_W{1'b0}}, r_cnt};
                n_cnt      = r_cnt + pgw_pkg::IDX_W'(1);
                if (r_cnt == {pgw_pkg::IDX_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_command;
                    n_va    = i_virtual_address;
                    n_pa    = {i_physical_address[pgw_pkg::PA_W-1:12], 12'h000};
                    n_flags = i_entry_flags;
                    n_level = '0;
                    n_page  = '0;
                    if (i_command == pgw_pkg::CMD_NONE) begin
                        n_done   = 1'b1;
                        n_status = pgw_pkg::ST_NOT_MAPPED;
                        n_phys   = '0;
                        n_inval  = 1'b0;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_done   = 1'b1;
                n_state  = S_IDLE;
                n_status = pgw_pkg::ST_NOT_MAPPED;
                n_phys   = '0;
                n_inval  = 1'b0;
                if (r_level != pgw_pkg::LEVEL_LEAF) begin
                    if (present) begin
                        // follow the pointer if it lands inside the pool
                        if (i_alu_rsp.in_pool) begin
                            n_done  = 1'b0;
                            n_page  = i_alu_rsp.sum[PAGE_W-1:0];
                            n_level = r_level + pgw_pkg::LVL_W'(1);
                            n_state = S_RD;
                        end
                    end else if (r_cmd == pgw_pkg::CMD_MAP) begin
                        if (r_pages_used == PU_W'(TABLE_PAGES)) begin
                            n_status = pgw_pkg::ST_EXHAUSTED;
                        end else begin
                            // allocate the next pool page
                            n_done       = 1'b0;
                            n_new_page   = r_pages_used[PAGE_W-1:0];
                            n_pages_used = r_pages_used + PU_W'(1);
                            n_cnt        = '0;
                            n_state      = S_ZERO;
                        end
                    end
                end else begin
                    case (r_cmd)
                        pgw_pkg::CMD_MAP: begin
                            o_ram_we    = 1'b1;
                            o_ram_wdata = {12'h000, r_pa[pgw_pkg::PA_W-1:12],
                                           r_flags | pgw_pkg::FL_PRESENT};
                            n_status    = pgw_pkg::ST_OK;
                            n_inval     = 1'b1;
                        end
                        pgw_pkg::CMD_UNMAP: begin
                            if (present) begin
                                o_ram_we = 1'b1;
                                n_status = pgw_pkg::ST_OK;
                                n_inval  = 1'b1;
                            end
                        end
                        pgw_pkg::CMD_XLATE: begin
                            if (present) begin
                                n_status = pgw_pkg::ST_OK;
                                n_phys   = {entry_frame, r_va[11:0]};
                            end
                        end
                        default: begin
                            n_status = pgw_pkg::ST_NOT_MAPPED;
                        end
                    endcase
                end
            end
            S_ZERO: begin
                // clear the freshly allocated page
                o_ram_we   = 1'b1;
                o_ram_addr = {r_new_page, r_cnt};
                n_cnt      = r_cnt + pgw_pkg::IDX_W'(1);
                if (r_cnt == {pgw_pkg::IDX_W{1'b1}}) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                // hook the new page into its parent and descend
                o_alu_req.op = pgw_pkg::ALU_ADD;
                o_alu_req.a  = i_base;
                o_alu_req.b  = {{(pgw_pkg::FRAME_W - PAGE_W){1'b0}}, r_new_page};
                o_ram_we     = 1'b1;
                o_ram_wdata  = {12'h000, i_alu_rsp.sum, pgw_pkg::FL_TABLE};
                n_page       = r_new_page;
                n_level      = r_level + pgw_pkg::LVL_W'(1);
                n_state      = S_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_BOOT;
            r_cnt        <= '0;
            r_level      <= '0;
            r_pages_used <= PU_W'(1);
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_level      <= n_level;
            r_pages_used <= n_pages_used;
            r_done       <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_page     <= n_page;
        r_new_page <= n_new_page;
        r_cmd      <= n_cmd;
        r_va       <= n_va;
        r_pa       <= n_pa;
        r_flags    <= n_flags;
        r_status   <= n_status;
        r_phys     <= n_phys;
        r_inval    <= n_inval;
    end

    assign o_busy               = (r_state != S_IDLE);
    assign o_done               = r_done;
    assign o_status             = r_status;
    assign o_physical_result    = r_phys;
    assign o_invalidate_request = r_inval;
    assign o_pages_used         = r_pages_used;

    `PGW_ASSERT_NOW(a_pool_bound, i_clk, i_rst_n, 1'b1, r_pages_used <= PU_W'(TABLE_PAGES), "pool count beyond table pages")
    `PGW_ASSERT_NEXT(a_walk_starts, i_clk, i_rst_n, i_start && !o_busy && i_command != pgw_pkg::CMD_NONE, o_busy, "transfer taken without walk")
    `PGW_ASSERT_NOW(a_leaf_write, i_clk, i_rst_n, r_state == S_CHK && o_ram_we, r_level == pgw_pkg::LEVEL_LEAF, "leaf write above leaf level")
    `PGW_ASSERT_NOW(a_alloc_map, i_clk, i_rst_n, r_state == S_ZERO, r_cmd == pgw_pkg::CMD_MAP, "page allocated outside map")
    `PGW_ASSERT_NOW(a_inval_ok, i_clk, i_rst_n, r_done && r_inval, r_status == pgw_pkg::ST_OK, "invalidate on failed command")

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // Package constants used here
    localparam int                         TABLE_PAGES_DEF = pgw_pkg::TABLE_PAGES_DEF;
    localparam int                         IDX_W           = pgw_pkg::IDX_W;
    localparam int                         FRAME_W         = pgw_pkg::FRAME_W;
    localparam int                         VA_W            = pgw_pkg::VA_W;
    localparam int                         PA_W            = pgw_pkg::PA_W;
    localparam int                         FLAG_W          = pgw_pkg::FLAG_W;
    localparam int                         ENTRY_W         = pgw_pkg::ENTRY_W;
    localparam int                         CMD_W           = pgw_pkg::CMD_W;
    localparam int                         ST_W            = pgw_pkg::ST_W;
    localparam logic [CMD_W-1:0]           CMD_MAP         = pgw_pkg::CMD_MAP;
    localparam logic [CMD_W-1:0]           CMD_UNMAP       = pgw_pkg::CMD_UNMAP;
    localparam logic [CMD_W-1:0]           CMD_XLATE       = pgw_pkg::CMD_XLATE;
    localparam logic [CMD_W-1:0]           CMD_NONE        = pgw_pkg::CMD_NONE;
    localparam logic [ST_W-1:0]            ST_OK           = pgw_pkg::ST_OK;
    localparam logic [ST_W-1:0]            ST_NOT_MAPPED   = pgw_pkg::ST_NOT_MAPPED;
    localparam logic [ST_W-1:0]            ST_EXHAUSTED    = pgw_pkg::ST_EXHAUSTED;
    localparam logic [FLAG_W-1:0]          FL_PRESENT      = pgw_pkg::FL_PRESENT;
    localparam logic [FLAG_W-1:0]          FL_TABLE        = pgw_pkg::FL_TABLE;

    localparam int POOL_PAGES      = TABLE_PAGES_DEF;
    localparam int ENTRIES         = 512;
    // Worst quiet stretch: a map that creates three tables plus
    // the walk itself, the root clear after reset and the longest sender gap
    localparam int STALL_LIMIT     = 6000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int RANDOM_PER_BASE = 232;
    localparam int MAX_REPORTS     = 10;

    // Pool bases visited: a mid value, the top (frames wrap), zero, then back
    localparam logic [FRAME_W-1:0] BASE_MID  = 40'h00_0001_2345;
    localparam logic [FRAME_W-1:0] BASE_TOP  = 40'hFF_FFFF_FFFF;
    localparam logic [FRAME_W-1:0] BASE_ZERO = 40'h00_0000_0000;

    // Upper three table indices of the regions that the stimulus works in
    localparam logic [26:0] PFX_LOW  = {9'd0,   9'd0,   9'd0};
    localparam logic [26:0] PFX_HIGH = {9'd511, 9'd511, 9'd511};
    localparam logic [26:0] PFX_NEAR = {9'd0,   9'd0,   9'd1};
    localparam logic [26:0] PFX_WRAP = {9'd5,   9'd300, 9'd300};
    localparam logic [26:0] PFX_ZB   = {9'd7,   9'd2,   9'd9};
    localparam logic [26:0] PFX_FULL = {9'd100, 9'd0,   9'd0};
    localparam logic [26:0] PFX_LATE = {9'd101, 9'd0,   9'd0};

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [PA_W-1:0] phys;
        logic            inval;
    } t_walk_reply;

    // Mirror of the table store; predicts one reply per accepted command
    class page_walk_scoreboard;
        logic [ENTRY_W-1:0] table_mem [POOL_PAGES * ENTRIES];
        int                 pages_used;
        logic [FRAME_W-1:0] pool_base;
        t_walk_reply        replies_due[$];
        int                 mismatches;
        int                 replies_seen;
        int                 full_seen;
        int                 cmd_seen[4];

        function new();
            int k;
            for (k = 0; k < POOL_PAGES * ENTRIES; k++) table_mem[k] = '0;
            pages_used   = 1;
            pool_base    = '0;
            mismatches   = 0;
            replies_seen = 0;
            full_seen    = 0;
            for (k = 0; k < 4; k++) cmd_seen[k] = 0;
        endfunction

        function void set_pool_base(input logic [FRAME_W-1:0] base);
            pool_base = base;
        endfunction

        // Walk the three upper levels, creating tables when grow is set
        function logic [ST_W-1:0] find_leaf(input logic [VA_W-1:0] va, input bit grow,
                                            output int slot);
            int                 page;
            int                 lvl;
            int                 pos;
            int                 np;
            int                 k;
            logic [ENTRY_W-1:0] ent;
            logic [FRAME_W-1:0] off;
            page = 0;
            slot = 0;
            for (lvl = 0; lvl < 3; lvl++) begin
                pos = page * ENTRIES + (int'(va >> (VA_W - IDX_W * (lvl + 1))) & (ENTRIES - 1));
                ent = table_mem[pos];
                if ((ent[FLAG_W-1:0] & FL_PRESENT) == '0) begin
                    if (!grow) return ST_NOT_MAPPED;
                    if (pages_used >= POOL_PAGES) return ST_EXHAUSTED;
                    np = pages_used;
                    pages_used++;
                    for (k = 0; k < ENTRIES; k++) table_mem[np * ENTRIES + k] = '0;
                    table_mem[pos] = {12'h000, pool_base + FRAME_W'(np), FL_TABLE};
                    page = np;
                end else begin
                    // A frame outside the allocated pool ends the walk
                    off = ent[PA_W-1:FLAG_W] - pool_base;
                    if (off >= FRAME_W'(pages_used)) return ST_NOT_MAPPED;
                    page = int'(off);
                end
            end
            slot = page * ENTRIES + (int'(va >> FLAG_W) & (ENTRIES - 1));
            return ST_OK;
        endfunction

        function void note_command(input logic [CMD_W-1:0] cmd, input logic [VA_W-1:0] va,
                                    input logic [PA_W-1:0] pa, input logic [FLAG_W-1:0] fl);
            t_walk_reply want;
            int          slot;
            want = '{status: ST_NOT_MAPPED, phys: '0, inval: 1'b0};
            cmd_seen[cmd]++;
            case (cmd)
                CMD_MAP: begin
                    want.status = find_leaf(va, 1'b1, slot);
                    if (want.status == ST_OK) begin
                        table_mem[slot] = {12'h000, pa[PA_W-1:FLAG_W], fl | FL_PRESENT};
                        want.inval = 1'b1;
                    end
                end
                CMD_UNMAP: begin
                    want.status = find_leaf(va, 1'b0, slot);
                    if (want.status == ST_OK) begin
                        if ((table_mem[slot][FLAG_W-1:0] & FL_PRESENT) != '0) begin
                            table_mem[slot] = '0;
                            want.inval = 1'b1;
                        end else begin
                            want.status = ST_NOT_MAPPED;
                        end
                    end
                end
                CMD_XLATE: begin
                    want.status = find_leaf(va, 1'b0, slot);
                    if (want.status == ST_OK) begin
                        if ((table_mem[slot][FLAG_W-1:0] & FL_PRESENT) != '0)
                            want.phys = {table_mem[slot][PA_W-1:FLAG_W], va[FLAG_W-1:0]};
                        else
                            want.status = ST_NOT_MAPPED;
                    end
                end
                default: ;
            endcase
            replies_due.push_back(want);
        endfunction

        function void check_reply(input logic [ST_W-1:0] status, input logic [PA_W-1:0] phys,
                                  input logic inval);
            t_walk_reply want;
            replies_seen++;
            if (status == ST_EXHAUSTED) full_seen++;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected reply: status %0d phys %h inval %0d",
                             status, phys, inval);
                return;
            end
            want = replies_due.pop_front();
            if (status !== want.status || phys !== want.phys || inval !== want.inval) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("reply mismatch: status %0d/%0d phys %h/%h inval %0d/%0d (exp/got)",
                             want.status, status, want.phys, phys, want.inval, inval);
            end
        endfunction
    endclass

    logic                i_clk              = 1'b0;
    logic                i_rst_n            = 1'b0;
    logic                i_cfg_we           = 1'b0;
    logic [FRAME_W-1:0]  i_cfg_wdata        = '0;
    logic                start              = 1'b0;
    logic [CMD_W-1:0]    i_command          = CMD_NONE;
    logic [VA_W-1:0]     i_virtual_address  = '0;
    logic [PA_W-1:0]     i_physical_address = '0;
    logic [FLAG_W-1:0]   i_entry_flags      = '0;
    logic                busy;
    logic                o_done;
    logic [ST_W-1:0]     o_status;
    logic [PA_W-1:0]     o_physical_result;
    logic                o_invalidate_request;

    page_walk_scoreboard sb;
    logic [26:0]         live_regions[$];
    int                  burst_left  = 1;
    int                  quiet_count = 0;

    four_level_page_table_walker #(.TABLE_PAGES(POOL_PAGES)) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .start                (start),
        .busy                 (busy),
        .i_command            (i_command),
        .i_virtual_address    (i_virtual_address),
        .i_physical_address   (i_physical_address),
        .i_entry_flags        (i_entry_flags),
        .o_done               (o_done),
        .o_status             (o_status),
        .o_physical_result    (o_physical_result),
        .o_invalidate_request (o_invalidate_request)
    );

    always #1 i_clk = ~i_clk;

    // Note each command transfer, check each reply and guard against a hang
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_command(i_command, i_virtual_address, i_physical_address, i_entry_flags);
        if (i_rst_n && o_done)
            sb.check_reply(o_status, o_physical_result, o_invalidate_request);
        if ((i_rst_n && start && !busy) || (i_rst_n && o_done))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("[four_level_page_table_walker] ERROR");
            $finish;
        end
    end

    function automatic logic [VA_W-1:0] va_at(input logic [26:0] region,
                                              input logic [IDX_W-1:0] leaf,
                                              input logic [FLAG_W-1:0] offset);
        return {region, leaf, offset};
    endfunction

    // Present one command and hold it until the block takes it
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [VA_W-1:0] va,
                         input logic [PA_W-1:0] pa, input logic [FLAG_W-1:0] fl);
        start              <= 1'b1;
        i_command          <= cmd;
        i_virtual_address  <= va;
        i_physical_address <= pa;
        i_entry_flags      <= fl;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Bursts of random length, random gaps, now and then a long unbroken stretch
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            if ($urandom_range(0, 5) == 0) begin
                burst_left = 40;
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 8);
                gap        = $urandom_range(0, 12);
            end
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [VA_W-1:0] va,
                        input logic [PA_W-1:0] pa, input logic [FLAG_W-1:0] fl);
        issue(cmd, va, pa, fl);
        pace_sender();
    endtask

    // Drop start, wait for every reply and let the block go quiet
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.replies_due.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pool_base(input logic [FRAME_W-1:0] base);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_pool_base(base);
    endtask

    // Mostly known regions with small leaf indices so that commands hit
    task automatic random_command(input bit noise_may_map);
        int                 roll;
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   leaf;
        logic [VA_W-1:0]    va;
        roll = $urandom_range(0, 99);
        if (roll < 35)      cmd = CMD_MAP;
        else if (roll < 55) cmd = CMD_UNMAP;
        else if (roll < 95) cmd = CMD_XLATE;
        else                cmd = CMD_NONE;
        roll = $urandom_range(0, 99);
        if (roll < 70)      leaf = IDX_W'($urandom_range(0, 7));
        else if (roll < 80) leaf = '1;
        else                leaf = IDX_W'($urandom);
        if ($urandom_range(0, 99) < 12) begin
            va = {16'($urandom), 32'($urandom)};
            if (cmd == CMD_MAP && !noise_may_map) cmd = CMD_XLATE;
        end else begin
            va = va_at(live_regions[$urandom_range(0, live_regions.size() - 1)], leaf,
                       FLAG_W'($urandom));
        end
        send(cmd, va, {20'($urandom), 32'($urandom)}, FLAG_W'($urandom));
    endtask

    task automatic random_run(input bit noise_may_map);
        int n;
        for (n = 0; n < RANDOM_PER_BASE; n++) random_command(noise_may_map);
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Hold off until the root page has been cleared
        while (busy) @(posedge i_clk);

        // Mid pool base: empty walks, fresh tables, extreme fields, remap, unused command
        write_pool_base(BASE_MID);
        send(CMD_XLATE, va_at(PFX_LOW, 9'd0, 12'h000), '0, '0);
        send(CMD_UNMAP, va_at(PFX_LOW, 9'd0, 12'h000), '0, '0);
        send(CMD_MAP,   va_at(PFX_LOW, 9'd0, 12'h000), '1, '0);
        send(CMD_XLATE, va_at(PFX_LOW, 9'd0, 12'hFFF), '0, '0);
        send(CMD_MAP,   '1, '0, '1);
        send(CMD_XLATE, '1, '0, '0);
        send(CMD_UNMAP, '1, '0, '0);
        send(CMD_UNMAP, '1, '0, '0);
        send(CMD_XLATE, '1, '0, '0);
        send(CMD_XLATE, va_at(PFX_LOW, 9'd1, 12'h000), '0, '0);
        send(CMD_NONE,  va_at(PFX_LOW, 9'd0, 12'h000), '1, '1);
        send(CMD_MAP,   va_at(PFX_NEAR, 9'd5, 12'h000), 52'h0_0000_0000_1FFF, 12'h800);
        send(CMD_MAP,   va_at(PFX_LOW, 9'd0, 12'h000), 52'h5_A5A5_A5A5_A5A5, 12'hA5A);
        send(CMD_XLATE, va_at(PFX_LOW, 9'd0, 12'h123), '0, '0);
        live_regions = '{PFX_LOW, PFX_HIGH, PFX_NEAR};
        random_run(1'b0);
        drain();

        // Top pool base: old tables turn stray, new frames wrap past zero
        write_pool_base(BASE_TOP);
        send(CMD_XLATE, va_at(PFX_LOW, 9'd0, 12'h000), '0, '0);
        send(CMD_MAP,   va_at(PFX_LOW, 9'd0, 12'h000), '1, '1);
        send(CMD_UNMAP, va_at(PFX_HIGH, 9'd511, 12'h000), '0, '0);
        send(CMD_MAP,   va_at(PFX_WRAP, 9'd0, 12'h000), 52'hA_0000_0000_0000, 12'h0FF);
        live_regions = '{PFX_WRAP, PFX_LOW, PFX_HIGH, PFX_NEAR};
        random_run(1'b0);
        drain();

        // Zero pool base: wrapped frames alias onto low pool pages
        write_pool_base(BASE_ZERO);
        send(CMD_MAP,   va_at(PFX_ZB, 9'd3, 12'h000), 52'h0_1234_5678_9000, 12'h001);
        send(CMD_XLATE, va_at(PFX_WRAP, 9'd0, 12'h0F0), '0, '0);
        live_regions = '{PFX_ZB, PFX_LOW, PFX_HIGH};
        random_run(1'b0);
        drain();

        // Back to the mid base: original tables return, then the pool runs out
        write_pool_base(BASE_MID);
        send(CMD_MAP,   va_at(PFX_FULL, 9'd0, 12'h000), '1, '1);
        send(CMD_MAP,   va_at(PFX_FULL, 9'd1, 12'h000), '1, '1);
        send(CMD_MAP,   va_at(PFX_LATE, 9'd0, 12'h000), '1, '1);
        send(CMD_XLATE, va_at(PFX_FULL, 9'd0, 12'h000), '0, '0);
        live_regions = '{PFX_LOW, PFX_HIGH, PFX_NEAR, PFX_WRAP, PFX_ZB, PFX_FULL};
        random_run(1'b1);
        drain();

        $display("covered %0d map, %0d unmap, %0d translate, %0d unused commands over four pool bases",
                 sb.cmd_seen[CMD_MAP], sb.cmd_seen[CMD_UNMAP], sb.cmd_seen[CMD_XLATE],
                 sb.cmd_seen[CMD_NONE]);
        $display("%0d replies checked, %0d with the pool full, %0d mismatches",
                 sb.replies_seen, sb.full_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.replies_due.size() == 0)
            $display("[four_level_page_table_walker] OK");
        else
            $display("[four_level_page_table_walker] ERROR");
        $finish;
    end

endmodule
